/* hw/rtl/audio_tail_fade_clipper_assert.svh */
// Assertion macros shared by the fade clipper RTL.
`ifndef AUDIO_TAIL_FADE_CLIPPER_ASSERT_SVH
`define AUDIO_TAIL_FADE_CLIPPER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ATFC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ATFC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/atfc_pkg.sv */
// Shared types and constants of the tail fade clipper.
`timescale 1ns / 1ps
`default_nettype none
package atfc_pkg;

	localparam int POS_W      = 41;
	localparam int END_W      = 40;
	localparam int TAIL_W     = 24;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 4;

	// Register select, taken from paddr[3] (64-bit registers at 8-byte stride).
	localparam logic REG_END_SAMPLE   = 1'b0;
	localparam logic REG_TAIL_SAMPLES = 1'b1;

	// Fade setting for one item, handed from the position tracker to the datapath.
	typedef struct packed {
		logic              fading;
		logic              last;
		logic [TAIL_W-1:0] num;
		logic [TAIL_W-1:0] den;
	} fade_ctrl_t;

endpackage
`default_nettype wire

/* hw/rtl/atfc_ifs.sv */
// Stream interfaces for sample items and PCM result items.
`timescale 1ns / 1ps
`default_nettype none
interface atfc_sample_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_in;
	logic signed [SAMPLE_BITS-1:0] right_in;

	modport source (output valid, output left_in, output right_in, input ready);
	modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface atfc_pcm_if #(
	parameter int PCM_BITS = 16
);
	logic                       valid;
	logic                       ready;
	logic signed [PCM_BITS-1:0] left_pcm;
	logic signed [PCM_BITS-1:0] right_pcm;
	logic                       clip_seen;
	logic                       last_sample;

	modport source (output valid, output left_pcm, output right_pcm,
		output clip_seen, output last_sample, input ready);
	modport sink (input valid, input left_pcm, input right_pcm,
		input clip_seen, input last_sample, output ready);
endinterface
`default_nettype wire

/* hw/rtl/atfc_pos.sv */
// Sample position counter and fade gain fraction for each item.
`timescale 1ns / 1ps
`default_nettype none
module atfc_pos (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [atfc_pkg::END_W-1:0]  end_sample,
	input  wire logic [atfc_pkg::TAIL_W-1:0] tail_samples,
	output      atfc_pkg::fade_ctrl_t        ctl,
	output      logic                       done
);
	import atfc_pkg::*;

	logic [POS_W-1:0]  pos_q;
	logic              v_s1;
	logic [POS_W-1:0]  offset_s1;
	logic              ge_s1;
	logic              last_s1;
	logic [POS_W:0]    diff;
	logic [POS_W-1:0]  last_pos;
	logic [TAIL_W-1:0] den;
	logic              in_range;
	fade_ctrl_t        ctl_q;
	logic              done_q;

	// Stage 1: offset into the tail, tail reached, last position.
	assign diff     = {1'b0, pos_q} - (POS_W + 1)'(end_sample);
	assign last_pos = POS_W'(end_sample) + POS_W'(tail_samples) - POS_W'(1);

	// Stage 2: gain numerator, clamped at zero past the tail.
	assign den      = tail_samples - TAIL_W'(1);
	assign in_range = (offset_s1[POS_W-1:TAIL_W] == '0) && (offset_s1[TAIL_W-1:0] < den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			v_s1   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			done_q <= v_s1;
			if (v_s1) begin
				pos_q <= last_s1 ? '0 : pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			offset_s1 <= diff[POS_W-1:0];
			ge_s1     <= !diff[POS_W];
			last_s1   <= (pos_q == last_pos);
		end
		if (v_s1) begin
			ctl_q.fading <= (tail_samples != '0) && ge_s1;
			ctl_q.last   <= last_s1;
			ctl_q.den    <= den;
			ctl_q.num    <= in_range ? den - offset_s1[TAIL_W-1:0] : '0;
		end
	end

	assign ctl  = ctl_q;
	assign done = done_q;

endmodule
`default_nettype wire

/* hw/rtl/atfc_chan.sv */
// Shared per-channel datapath: fade multiply, restoring divide, clip, PCM scale.
`timescale 1ns / 1ps
`default_nettype none
`include "audio_tail_fade_clipper_assert.svh"
module atfc_chan #(
	parameter int SAMPLE_BITS = 24,
	parameter int PCM_BITS    = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [SAMPLE_BITS-1:0] mag,
	input  wire logic                   neg,
	input  wire atfc_pkg::fade_ctrl_t   ctl,
	output      logic                   done,
	output      logic                   clip,
	output      logic [PCM_BITS-1:0]    pcm
);
	import atfc_pkg::*;

	localparam int FRAC_BITS = SAMPLE_BITS - 4;
	localparam int PW        = SAMPLE_BITS + TAIL_W;
	localparam int RW        = TAIL_W + 1;
	localparam int CW        = $clog2(SAMPLE_BITS);
	localparam logic [SAMPLE_BITS-1:0] ONE_Q = SAMPLE_BITS'(64'd1 << FRAC_BITS);
	localparam logic [TAIL_W-1:0] PCM_SCALE = TAIL_W'((64'd1 << (PCM_BITS - 1)) - 64'd1);
	localparam logic [PW-1:0] HALF_Q = PW'(64'd1 << (FRAC_BITS - 1));

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_LOAD  = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_CLIP  = 3'd4;
	localparam logic [2:0] S_SCALE = 3'd5;
	localparam logic [2:0] S_ROUND = 3'd6;

	logic [2:0]             state_q;
	logic [CW-1:0]          cnt_q;
	logic                   done_q;
	logic                   clip_q;
	logic [SAMPLE_BITS-1:0] mag_q;
	logic                   neg_q;
	logic [PW-1:0]          prod_q;
	logic [RW-1:0]          rem_q;
	logic [RW-1:0]          dvs_q;
	logic [SAMPLE_BITS-1:0] quo_q;
	logic [PCM_BITS-1:0]    pcm_q;

	logic [TAIL_W-1:0]      mul_b;
	logic [PW-1:0]          prod_c;
	logic [PW:0]            dividend;
	logic [RW:0]            r2;
	logic [RW:0]            r2_sub;
	logic                   q_bit;
	logic [SAMPLE_BITS-1:0] quo_next;
	logic [PW-1:0]          rnd_sum;
	logic [PW-1:0]          rnd_shift;
	logic [PCM_BITS-1:0]    pcm_mag;

	// One multiplier serves both the fade product and the PCM scale.
	assign mul_b  = (state_q == S_MUL) ? ctl.num : PCM_SCALE;
	assign prod_c = PW'(mag_q) * PW'(mul_b);

	// Rounded quotient: (2*mag*num + den) / (2*den).
	assign dividend = {prod_q, 1'b0} + (PW + 1)'(ctl.den);

	// One restoring step per cycle.
	assign r2       = {rem_q, quo_q[SAMPLE_BITS-1]};
	assign r2_sub   = r2 - {1'b0, dvs_q};
	assign q_bit    = (r2 >= {1'b0, dvs_q});
	assign quo_next = {quo_q[SAMPLE_BITS-2:0], q_bit};

	assign rnd_sum   = prod_q + HALF_Q;
	assign rnd_shift = rnd_sum >> FRAC_BITS;
	assign pcm_mag   = rnd_shift[PCM_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			clip_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						clip_q  <= 1'b0;
						state_q <= (ctl.fading && ctl.num != '0 && ctl.den != '0) ?
							S_MUL : S_CLIP;
					end
				end
				S_MUL: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					cnt_q   <= CW'(SAMPLE_BITS - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == '0) begin
						state_q <= S_CLIP;
					end
				end
				S_CLIP: begin
					if (mag_q > ONE_Q) begin
						clip_q <= 1'b1;
					end
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					neg_q <= neg;
					mag_q <= (ctl.fading && (ctl.num == '0 || ctl.den == '0)) ? '0 : mag;
				end
			end
			S_MUL: begin
				prod_q <= prod_c;
			end
			S_LOAD: begin
				rem_q <= dividend[PW:SAMPLE_BITS];
				quo_q <= dividend[SAMPLE_BITS-1:0];
				dvs_q <= {ctl.den, 1'b0};
			end
			S_DIV: begin
				rem_q <= q_bit ? r2_sub[RW-1:0] : r2[RW-1:0];
				quo_q <= quo_next;
				if (cnt_q == '0) begin
					mag_q <= quo_next;
				end
			end
			S_CLIP: begin
				if (mag_q > ONE_Q) begin
					mag_q <= ONE_Q;
				end
			end
			S_SCALE: begin
				prod_q <= prod_c;
			end
			S_ROUND: begin
				pcm_q <= neg_q ? PCM_BITS'(0) - pcm_mag : pcm_mag;
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign clip = clip_q;
	assign pcm  = pcm_q;

	`ATFC_ASSERT_IMP(a_rem_below_divisor, clk, arst_n, state_q == S_DIV, rem_q < dvs_q, "divider remainder not below divisor")
	`ATFC_ASSERT_IMP(a_quo_not_above_mag, clk, arst_n, state_q == S_DIV && cnt_q == '0, quo_next <= mag_q, "faded magnitude exceeds input magnitude")
	`ATFC_ASSERT_IMP(a_scale_after_clip, clk, arst_n, state_q == S_SCALE, mag_q <= ONE_Q, "magnitude above full scale reached PCM scaling")

endmodule
`default_nettype wire

/* hw/rtl/audio_tail_fade_clipper.sv */
// Top level of the tail fade clipper: channels, config registers, sequencer.
// Usage:
//   sample_ch carries one stereo pair per item (left_in, right_in, signed Q4.20
//   with SAMPLE_BITS-4 fraction bits). pcm_ch returns one item per input item:
//   left_pcm/right_pcm as PCM_BITS signed PCM, the sticky clip_seen flag and
//   last_sample, set on position end_sample + tail_samples - 1.
//   Both channels are valid/ready; an item moves when both are high.
//   end_sample sits at byte address 0, tail_samples at 8 on the 64-bit APB port.
// Timing:
//   The block takes one item at a time. In the fade tail at nonzero gain both
//   channels pass in turn through one multiplier and a one-bit-per-cycle
//   restoring divider; otherwise the divide is skipped. The result goes valid
//   in the same cycle as the input is ready again.
// Reset and stalls:
//   arst_n clears both registers, the sample position and the clip flag.
//   A stalled receiver holds the result register; the next item is still taken
//   and worked, and its result waits until the register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "audio_tail_fade_clipper_assert.svh"
module audio_tail_fade_clipper #(
	parameter int SAMPLE_BITS = 24,
	parameter int PCM_BITS    = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	atfc_sample_if.sink                         sample_ch,
	atfc_pcm_if.source                          pcm_ch,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [atfc_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [atfc_pkg::CFG_DATA_W-1:0] pwdata,
	output      logic [atfc_pkg::CFG_DATA_W-1:0] prdata,
	output      logic                           pready
);
	import atfc_pkg::*;

	localparam logic [2:0] T_IDLE  = 3'd0;
	localparam logic [2:0] T_POS   = 3'd1;
	localparam logic [2:0] T_LEFT  = 3'd2;
	localparam logic [2:0] T_RIGHT = 3'd3;
	localparam logic [2:0] T_OUT   = 3'd4;

	logic [2:0]             state_q;
	logic [END_W-1:0]       end_sample_q;
	logic [TAIL_W-1:0]      tail_samples_q;
	logic                   clip_sticky_q;
	logic                   out_valid_q;

	logic [SAMPLE_BITS-1:0] mag_l_q;
	logic [SAMPLE_BITS-1:0] mag_r_q;
	logic                   neg_l_q;
	logic                   neg_r_q;
	logic [PCM_BITS-1:0]    pcm_l_q;
	logic [PCM_BITS-1:0]    out_l_q;
	logic [PCM_BITS-1:0]    out_r_q;
	logic                   out_clip_q;
	logic                   out_last_q;

	logic                   accept;
	logic                   cfg_wr;
	logic                   pos_done;
	fade_ctrl_t             fade_ctl;
	logic                   chan_start;
	logic                   chan_right;
	logic                   chan_done;
	logic                   chan_clip;
	logic [PCM_BITS-1:0]    chan_pcm;
	logic                   out_load;
	logic [SAMPLE_BITS-1:0] raw_l;
	logic [SAMPLE_BITS-1:0] raw_r;

	// ---------------- config port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_sample_q   <= '0;
			tail_samples_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[3])
				REG_END_SAMPLE:   end_sample_q   <= pwdata[END_W-1:0];
				REG_TAIL_SAMPLES: tail_samples_q <= pwdata[TAIL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3])
			REG_END_SAMPLE:   prdata = CFG_DATA_W'(end_sample_q);
			REG_TAIL_SAMPLES: prdata = CFG_DATA_W'(tail_samples_q);
			default:          prdata = '0;
		endcase
	end

	// ---------------- input side ----------------
	// Take a new item only while the sequencer is free.
	assign sample_ch.ready = (state_q == T_IDLE);
	assign accept          = sample_ch.valid && sample_ch.ready;

	assign raw_l = sample_ch.left_in;
	assign raw_r = sample_ch.right_in;

	// Hold magnitude and sign of both channels for the shared datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_l_q <= raw_l[SAMPLE_BITS-1];
			neg_r_q <= raw_r[SAMPLE_BITS-1];
			mag_l_q <= raw_l[SAMPLE_BITS-1] ? SAMPLE_BITS'(0) - raw_l : raw_l;
			mag_r_q <= raw_r[SAMPLE_BITS-1] ? SAMPLE_BITS'(0) - raw_r : raw_r;
		end
	end

	// ---------------- position tracker ----------------
	atfc_pos u_pos (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (accept),
		.end_sample   (end_sample_q),
		.tail_samples (tail_samples_q),
		.ctl          (fade_ctl),
		.done         (pos_done)
	);

	// ---------------- shared channel datapath ----------------
	// Left starts when the fade setting is ready, right when left is done.
	assign chan_right = (state_q == T_LEFT);
	assign chan_start = ((state_q == T_POS) && pos_done) || ((state_q == T_LEFT) && chan_done);

	atfc_chan #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.PCM_BITS    (PCM_BITS)
	) u_chan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (chan_start),
		.mag    (chan_right ? mag_r_q : mag_l_q),
		.neg    (chan_right ? neg_r_q : neg_l_q),
		.ctl    (fade_ctl),
		.done   (chan_done),
		.clip   (chan_clip),
		.pcm    (chan_pcm)
	);

	// ---------------- sequencer ----------------
	// Load the result register only when it is empty or being drained.
	assign out_load = (state_q == T_OUT) && (!out_valid_q || pcm_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= T_IDLE;
			clip_sticky_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (chan_done && chan_clip) begin
				clip_sticky_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pcm_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (accept) begin
						state_q <= T_POS;
					end
				end
				T_POS: begin
					if (pos_done) begin
						state_q <= T_LEFT;
					end
				end
				T_LEFT: begin
					if (chan_done) begin
						state_q <= T_RIGHT;
					end
				end
				T_RIGHT: begin
					if (chan_done) begin
						state_q <= T_OUT;
					end
				end
				T_OUT: begin
					if (out_load) begin
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == T_LEFT) && chan_done) begin
			pcm_l_q <= chan_pcm;
		end
		if (out_load) begin
			out_l_q    <= pcm_l_q;
			out_r_q    <= chan_pcm;
			out_clip_q <= clip_sticky_q;
			out_last_q <= fade_ctl.last;
		end
	end

	// ---------------- output side ----------------
	assign pcm_ch.valid       = out_valid_q;
	assign pcm_ch.left_pcm    = out_l_q;
	assign pcm_ch.right_pcm   = out_r_q;
	assign pcm_ch.clip_seen   = out_clip_q;
	assign pcm_ch.last_sample = out_last_q;

	`ATFC_ASSERT_NXT(a_busy_after_accept, clk, arst_n, accept, !sample_ch.ready, "new item taken while previous one in flight")
	`ATFC_ASSERT_IMP(a_clip_sticky, clk, arst_n, 1'b1, !$fell(clip_sticky_q), "clip flag cleared outside reset")
	`ATFC_ASSERT_IMP(a_no_overwrite, clk, arst_n, out_load, !out_valid_q || pcm_ch.ready, "pending result overwritten")

endmodule
`default_nettype wire

/* test/audio_tail_fade_clipper_tb.sv */
// Self-checking testbench for the tail fade clipper: directed shapes, then random renders.
`timescale 1ns / 1ps
module audio_tail_fade_clipper_tb;
	import atfc_pkg::*;

	localparam int SAMPLE_W = 24;
	localparam int PCM_W    = 16;
	localparam int FRAC_W   = SAMPLE_W - 4;
	localparam int UNITY_I  = 1 << FRAC_W;

	// Q4.20 unity and the PCM full-scale multiplier.
	localparam logic [63:0] UNITY    = 64'd1 << FRAC_W;
	localparam logic [63:0] PCM_FULL = (64'd1 << (PCM_W - 1)) - 64'd1;

	// Sample extremes used by the directed part.
	localparam logic [SAMPLE_W-1:0] S_ONE = SAMPLE_W'(UNITY_I);
	localparam logic [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	// Register byte addresses: the register select sits on paddr[3].
	localparam logic [CFG_ADDR_W-1:0] ADDR_END_SAMPLE   = {REG_END_SAMPLE, 3'd0};
	localparam logic [CFG_ADDR_W-1:0] ADDR_TAIL_SAMPLES = {REG_TAIL_SAMPLES, 3'd0};

	localparam int RANDOM_ITEMS  = 1700;
	localparam int IDLE_PCT      = 6;
	localparam int STALL_HOLD    = 1000;
	localparam int MAX_REACH     = 400;
	localparam int SETTLE_CYCLES = 80;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int CYCLE_LIMIT   = 1_000_000;

	typedef struct packed {
		logic [PCM_W-1:0] left_pcm;
		logic [PCM_W-1:0] right_pcm;
		logic             clip_seen;
		logic             last_sample;
	} pcm_item_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	atfc_sample_if #(.SAMPLE_BITS(SAMPLE_W)) sample_ch ();
	atfc_pcm_if #(.PCM_BITS(PCM_W)) pcm_ch ();

	audio_tail_fade_clipper #(
		.SAMPLE_BITS(SAMPLE_W),
		.PCM_BITS(PCM_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_ch(sample_ch),
		.pcm_ch(pcm_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Mirror of the block state: position counter, sticky clip flag and the
	// two registers as last written.
	logic [POS_W-1:0]  pos_model;
	logic [END_W-1:0]  end_model;
	logic [TAIL_W-1:0] tail_model;
	logic              clip_model;
	bit                last_hit;

	// Expected PCM items, oldest first.
	pcm_item_t pcm_expected[$];

	int  items_sent;
	int  results_checked;
	int  mismatches;
	int  renders_done;
	int  tail_items;
	int  clip_items;
	int  cycles;
	bit  idle_on;
	int  hold_requests;
	int  hold_taken;
	int  hold_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still due", cycles,
				pcm_expected.size());
			$display("audio_tail_fade_clipper regression: fail");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("MISMATCH: %s", msg);
	endtask

	// Fade, clip and scale one channel. Rounding is half away from zero on the
	// magnitude, both in the fade and in the PCM scaling; the clip test is made
	// on the rounded faded value.
	function automatic logic [PCM_W-1:0] fade_to_pcm(input logic [SAMPLE_W-1:0] x,
			input bit fading, input logic [TAIL_W-1:0] num, input logic [TAIL_W-1:0] den,
			output bit clipped);
		logic [63:0] mag;
		logic [63:0] pcm;
		bit          neg;
		neg = x[SAMPLE_W-1];
		mag = neg ? (64'd1 << SAMPLE_W) - 64'(x) : 64'(x);
		if (fading) begin
			if (den == 0 || num == 0)
				mag = '0;
			else
				mag = (64'd2 * mag * 64'(num) + 64'(den)) / (64'd2 * 64'(den));
		end
		clipped = mag > UNITY;
		if (clipped)
			mag = UNITY;
		pcm = (mag * PCM_FULL + (UNITY >> 1)) >> FRAC_W;
		if (neg)
			pcm = -pcm;
		return pcm[PCM_W-1:0];
	endfunction

	// Work out the PCM item for one accepted stereo pair and advance the
	// position counter, wrapping to zero on the final sample of the render.
	task automatic predict_pcm(input logic [SAMPLE_W-1:0] left, input logic [SAMPLE_W-1:0] right);
		logic [POS_W-1:0]  last_pos;
		logic [POS_W-1:0]  offset;
		logic [TAIL_W-1:0] num;
		logic [TAIL_W-1:0] den;
		bit                fading;
		bit                left_clip;
		bit                right_clip;
		pcm_item_t         item;
		last_pos = POS_W'(end_model) + POS_W'(tail_model) - 1'b1;
		fading = 1'b0;
		num = '0;
		den = '0;
		if (tail_model != 0 && pos_model >= POS_W'(end_model)) begin
			offset = pos_model - POS_W'(end_model);
			fading = 1'b1;
			den = tail_model - 1'b1;
			num = (offset < POS_W'(den)) ? den - offset[TAIL_W-1:0] : '0;
		end
		item.left_pcm = fade_to_pcm(left, fading, num, den, left_clip);
		item.right_pcm = fade_to_pcm(right, fading, num, den, right_clip);
		if (left_clip || right_clip) begin
			clip_model = 1'b1;
			clip_items++;
		end
		item.clip_seen = clip_model;
		item.last_sample = (pos_model == last_pos);
		last_hit = item.last_sample;
		pos_model = item.last_sample ? '0 : pos_model + 1'b1;
		if (fading)
			tail_items++;
		pcm_expected.push_back(item);
	endtask

	// Offer one stereo pair, with a random gap first, and hold it until taken.
	// Valid stays high on return so back-to-back items need no extra step.
	task automatic send_pair(input logic [SAMPLE_W-1:0] left, input logic [SAMPLE_W-1:0] right);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.left_in <= left;
		sample_ch.right_in <= right;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		predict_pcm(left, right);
		items_sent++;
	endtask

	// Mix of full-range noise, in-range audio, values within two of plus or
	// minus unity and small values around zero.
	function automatic logic [SAMPLE_W-1:0] rand_sample();
		int pick;
		int val;
		pick = $urandom_range(9);
		if (pick < 3)
			val = int'($urandom());
		else if (pick < 7)
			val = int'($urandom_range(2 * UNITY_I)) - UNITY_I;
		else if (pick < 9)
			val = (UNITY_I + int'($urandom_range(4)) - 2) * ($urandom_range(1) ? 1 : -1);
		else
			val = int'($urandom_range(128)) - 64;
		return SAMPLE_W'(val);
	endfunction

	// Compare the PCM item on the output with the oldest expectation.
	task automatic check_pcm_item();
		pcm_item_t got;
		pcm_item_t want;
		got = {pcm_ch.left_pcm, pcm_ch.right_pcm, pcm_ch.clip_seen, pcm_ch.last_sample};
		results_checked++;
		if (pcm_expected.size() == 0) begin
			report_mismatch($sformatf("unexpected PCM item L=%0d R=%0d clip=%0b last=%0b",
				$signed(got.left_pcm), $signed(got.right_pcm), got.clip_seen,
				got.last_sample));
			return;
		end
		want = pcm_expected.pop_front();
		if (got.left_pcm !== want.left_pcm || got.right_pcm !== want.right_pcm ||
				got.clip_seen !== want.clip_seen || got.last_sample !== want.last_sample)
			report_mismatch($sformatf(
				"result %0d: expected L=%0d R=%0d clip=%0b last=%0b, got L=%0d R=%0d clip=%0b last=%0b",
				results_checked, $signed(want.left_pcm), $signed(want.right_pcm),
				want.clip_seen, want.last_sample, $signed(got.left_pcm),
				$signed(got.right_pcm), got.clip_seen, got.last_sample));
	endtask

	// Output side: check every accepted item, then pick ready for the next
	// cycle. A hold request drops ready for a long stretch so that the block
	// fills up and stalls its input.
	always @(posedge clk) begin
		if (arst_n && pcm_ch.valid && pcm_ch.ready)
			check_pcm_item();
		if (hold_taken != hold_requests) begin
			hold_taken <= hold_requests;
			hold_left <= STALL_HOLD;
			pcm_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			pcm_ch.ready <= 1'b0;
		end else begin
			pcm_ch.ready <= arst_n && !(idle_on && $urandom_range(99) < IDLE_PCT);
		end
	end

	// APB transfers: setup, access, then idle with psel low so that the next
	// transfer never drives psel twice in one step.
	task automatic reg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_read(input logic [CFG_ADDR_W-1:0] addr, output logic [CFG_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Drop valid and hold off until every expected item has come back.
	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		while (pcm_expected.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Retune both registers once the block is idle. Upper data bits carry
	// noise, which the block must drop; read both back.
	task automatic program_render(input logic [END_W-1:0] end_pos, input logic [TAIL_W-1:0] tail_len);
		logic [CFG_DATA_W-1:0] noise;
		logic [CFG_DATA_W-1:0] readback;
		wait_drained();
		noise = {$urandom(), $urandom()};
		reg_write(ADDR_END_SAMPLE, {noise[CFG_DATA_W-1:END_W], end_pos});
		end_model = end_pos;
		noise = {$urandom(), $urandom()};
		reg_write(ADDR_TAIL_SAMPLES, {noise[CFG_DATA_W-1:TAIL_W], tail_len});
		tail_model = tail_len;
		reg_read(ADDR_END_SAMPLE, readback);
		if (readback[END_W-1:0] !== end_pos)
			report_mismatch($sformatf("end_sample reads %0h, written %0h",
				readback[END_W-1:0], end_pos));
		reg_read(ADDR_TAIL_SAMPLES, readback);
		if (readback[TAIL_W-1:0] !== tail_len)
			report_mismatch($sformatf("tail_samples reads %0h, written %0h",
				readback[TAIL_W-1:0], tail_len));
	endtask

	// One render: program it, optionally play part of it and then move the
	// tail under the running counter, and play on to the final sample. A
	// render whose end lies out of reach is always cut short and moved.
	task automatic run_render(input logic [END_W-1:0] end_pos, input logic [TAIL_W-1:0] tail_len,
			input bit cut_short);
		logic [POS_W-1:0] last_pos;
		logic [POS_W-1:0] reach;
		int unsigned      back;
		program_render(end_pos, tail_len);
		last_hit = 1'b0;
		last_pos = POS_W'(end_pos) + POS_W'(tail_len) - 1'b1;
		reach = last_pos - pos_model;
		if (cut_short || reach > MAX_REACH) begin
			repeat ($urandom_range(1, 24))
				if (!last_hit)
					send_pair(rand_sample(), rand_sample());
			if (!last_hit) begin
				// Restart the tail a little behind the counter so the fade
				// picks up mid-way.
				back = $urandom_range(12);
				if (pos_model < POS_W'(back))
					back = pos_model[31:0];
				program_render(END_W'(pos_model - POS_W'(back)),
					TAIL_W'(back + $urandom_range(1, 30)));
			end
		end
		while (!last_hit)
			send_pair(rand_sample(), rand_sample());
		renders_done++;
	endtask

	// No fade at all: rounding edges of the PCM scaling, unity, and the
	// clip threshold; clip-free items go first since the flag is sticky.
	task automatic test_passthrough_extremes();
		program_render('0, '0);
		send_pair('0, -SAMPLE_W'(1));
		send_pair(SAMPLE_W'(16), SAMPLE_W'(17));
		send_pair(-SAMPLE_W'(16), -SAMPLE_W'(17));
		send_pair(S_ONE - 1'b1, 1'b1 - S_ONE);
		send_pair(S_ONE, -S_ONE);
		send_pair(S_ONE + 1'b1, '0);
		send_pair('0, -(S_ONE + 1'b1));
		send_pair(S_MAX, S_MIN);
		send_pair(S_MIN, S_MAX);
		send_pair(SAMPLE_W'(24'h555555), SAMPLE_W'(24'hAAAAAA));
	endtask

	// Short fade with the tail set just ahead of the running counter, a
	// one-sample tail, register extremes, and silence past the tail.
	task automatic test_fade_shapes();
		program_render(END_W'(pos_model + 1'b1), TAIL_W'(3));
		repeat (4)
			send_pair(S_ONE, -(S_ONE + (S_ONE >> 1)));
		program_render('0, TAIL_W'(1));
		send_pair(S_MAX, S_MIN);
		send_pair(S_ONE, -S_ONE);
		program_render('1, '1);
		send_pair(S_MAX, S_ONE);
		send_pair(S_MIN, -S_ONE);
		// Tail ends behind the counter: gain is zero and no last is flagged.
		program_render('0, TAIL_W'(2));
		send_pair(S_MAX, S_MIN);
		send_pair(S_ONE, S_ONE);
		program_render(END_W'(pos_model), TAIL_W'(1));
		send_pair(S_ONE, S_MIN);
		renders_done += 3;
	endtask

	// Stall the output for a long stretch while a render keeps offering items.
	// The hold starts only once the render is programmed, so the sender is
	// still pushing items while the receiver holds off.
	task automatic test_backpressure();
		program_render(END_W'(pos_model + POS_W'(20)), TAIL_W'(40));
		hold_requests++;
		last_hit = 1'b0;
		while (!last_hit)
			send_pair(rand_sample(), rand_sample());
		renders_done++;
	endtask

	task automatic test_random_renders(input int count);
		int                target;
		int                pick;
		logic [TAIL_W-1:0] tail_len;
		target = items_sent + count;
		while (items_sent < target) begin
			// Keep both sides busy without gaps for a few hundred items.
			idle_on = !(items_sent - (target - count) >= 600 &&
				items_sent - (target - count) < 1000);
			pick = $urandom_range(9);
			tail_len = (pick == 0) ? '0 : (pick == 1) ? TAIL_W'(1) : (pick == 2) ? TAIL_W'(2) :
				TAIL_W'($urandom_range(3, 48));
			pick = $urandom_range(99);
			if (pick < 60)
				run_render(END_W'($urandom_range(48)), tail_len, $urandom_range(4) == 0);
			else if (pick < 75)
				run_render(END_W'($urandom_range(8)), $urandom_range(3) == 0 ? '1 :
					TAIL_W'($urandom_range(1000, (1 << TAIL_W) - 1)), 1'b1);
			else if (pick < 85)
				run_render($urandom_range(3) == 0 ? '1 : END_W'({$urandom(), $urandom()}),
					tail_len, 1'b1);
			else if (pick < 92)
				run_render('0, TAIL_W'($urandom_range(2)), $urandom_range(1));
			else
				run_render(END_W'($urandom_range(48)), TAIL_W'($urandom_range(48)), 1'b1);
		end
		idle_on = 1'b1;
	endtask

	initial begin
		int waited;
		// Drive every input to a known value before the first edge.
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.left_in = '0;
		sample_ch.right_in = '0;
		pcm_ch.ready = 1'b0;
		pos_model = '0;
		end_model = '0;
		tail_model = '0;
		clip_model = 1'b0;
		last_hit = 1'b0;
		idle_on = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_passthrough_extremes();
		test_fade_shapes();
		test_backpressure();
		test_random_renders(RANDOM_ITEMS);

		// Let the last results out, then watch for stray items.
		sample_ch.valid <= 1'b0;
		waited = 0;
		while (pcm_expected.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pcm_expected.size() != 0)
			report_mismatch($sformatf("%0d PCM items never arrived", pcm_expected.size()));

		$display("Sent %0d sample items over %0d renders; %0d in a fade tail, %0d clipping.",
			items_sent, renders_done, tail_items, clip_items);
		$display("Checked %0d PCM items, register readback and a %0d-cycle output stall; %0d mismatches.",
			results_checked, STALL_HOLD, mismatches);
		if (mismatches == 0)
			$display("audio_tail_fade_clipper regression: pass");
		else
			$display("audio_tail_fade_clipper regression: fail");
		$finish;
	end

endmodule

/* audio_tail_fade_clipper.f */
+incdir+hw/rtl
hw/rtl/atfc_pkg.sv
hw/rtl/atfc_ifs.sv
hw/rtl/atfc_pos.sv
hw/rtl/atfc_chan.sv
hw/rtl/audio_tail_fade_clipper.sv
test/audio_tail_fade_clipper_tb.sv
